[hw/rtl/truncated_time_of_day_expander_top_assert.svh]
// Assertion shorthands shared by the expander RTL.
// Each expects clk and rst_n in scope.
`ifndef TRUNCATED_TIME_OF_DAY_EXPANDER_TOP_ASSERT_SVH
`define TRUNCATED_TIME_OF_DAY_EXPANDER_TOP_ASSERT_SVH

// Same-cycle implication
`define TTDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttde assertion failed");

// Next-cycle implication
`define TTDE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttde assertion failed");

`endif

[hw/rtl/ttde_pkg.sv]
package ttde_pkg;

    // Field widths
    localparam int SEC_W  = 34;
    localparam int NSEC_W = 30;
    localparam int LSP_W  = 16;
    localparam int TOD_W  = 24;
    localparam int FRAC_W = 7;

    // Day and tick constants (1/128 s ticks)
    localparam int DAY_SECONDS   = 86400;
    localparam int TICKS_PER_SEC = 128;
    localparam logic [TOD_W-1:0] DAY_TICKS  = TOD_W'(DAY_SECONDS * TICKS_PER_SEC);
    localparam logic [TOD_W-1:0] HALF_TICKS = TOD_W'(DAY_SECONDS * TICKS_PER_SEC / 2);
    localparam int HIGH_W = TOD_W - LSP_W;
    localparam logic [HIGH_W-1:0] TOP_HIGH =
        HIGH_W'((DAY_SECONDS * TICKS_PER_SEC - 1) >> LSP_W);

    // Seconds mod day: day = 675 groups of 128 s, reduce sec >> 7 mod 675
    localparam int SEC_HI_W        = SEC_W - FRAC_W;
    localparam int SEC_GROUPS      = DAY_SECONDS / TICKS_PER_SEC;
    localparam int SEC_RECIP_SHIFT = 36;
    localparam logic [SEC_HI_W-1:0] SEC_RECIP =
        SEC_HI_W'((64'd1 << SEC_RECIP_SHIFT) / SEC_GROUPS);
    localparam int SEC_PROD_W = 2 * SEC_HI_W;
    localparam int SEC_Q_W    = SEC_PROD_W - SEC_RECIP_SHIFT;
    localparam int SEC_REM_W  = 10;

    // Nanoseconds to ticks: one tick is 7812500 ns
    localparam logic [NSEC_W-1:0] NSEC_MAX      = NSEC_W'(999999999);
    localparam logic [NSEC_W-1:0] NSEC_PER_TICK = NSEC_W'(1000000000 / 128);
    localparam int NSEC_RECIP_SHIFT = 52;
    localparam logic [NSEC_W-1:0] NSEC_RECIP =
        NSEC_W'((64'd1 << NSEC_RECIP_SHIFT) / (1000000000 / 128));
    localparam int NSEC_PROD_W = 2 * NSEC_W;

    // Reference time and report fields handed to the expand stage
    typedef struct packed {
        logic [TOD_W-1:0] ticks;
        logic             lsp_present;
        logic [LSP_W-1:0] tod_lsp;
    } ttde_arr_t;

endpackage

[hw/rtl/ttde_if.sv]
interface ttde_report_if;
    import ttde_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEC_W-1:0]  arrival_sec;
    logic [NSEC_W-1:0] arrival_nsec;
    logic              lsp_present;
    logic [LSP_W-1:0]  tod_lsp;

    modport source (output valid, arrival_sec, arrival_nsec, lsp_present, tod_lsp,
                    input ready);
    modport sink (input valid, arrival_sec, arrival_nsec, lsp_present, tod_lsp,
                  output ready);
endinterface

interface ttde_result_if;
    import ttde_pkg::*;

    logic             valid;
    logic             ready;
    logic [TOD_W-1:0] time_of_day;
    logic             from_arrival;

    modport source (output valid, time_of_day, from_arrival, input ready);
    modport sink (input valid, time_of_day, from_arrival, output ready);
endinterface

[hw/rtl/truncated_time_of_day_expander_top.sv]
// Truncated time-of-day expander.
// The report channel takes one decoded report per transaction: arrival time
// (seconds, nanoseconds), a present flag and the 16-bit truncated time of day.
// The result channel returns one transaction per report: the full time of day
// in 1/128 s ticks and a flag telling whether the reference was the arrival
// time (no anchor yet) or the anchor left by the previous report.
// Throughput: one report per cycle while the result receiver is ready. The
// accepting edge loads the input register, then come the reciprocal multiply,
// remainder correction and expansion into the result register; the two
// reciprocal multiplies and their correction step set the depth.
// The anchor is read and written only in the last stage, so back-to-back
// reports see the anchor of the report just before them.
// Reset clears all stage valid bits and the anchor; the first report after
// reset uses its arrival time as reference.
// When the result receiver stalls, the result holds and the stages behind it
// keep accepting until each holds a report, then report ready drops.
module truncated_time_of_day_expander_top (
    input logic          clk,
    input logic          rst_n,
    ttde_report_if.sink  report,
    ttde_result_if.source result
);
    import ttde_pkg::*;

    logic      arr_valid;
    logic      arr_ready;
    ttde_arr_t arr;

    // Arrival time to day ticks
    ttde_arrival u_arrival (
        .clk       (clk),
        .rst_n     (rst_n),
        .report    (report),
        .arr_valid (arr_valid),
        .arr_ready (arr_ready),
        .arr       (arr)
    );

    // Window selection against the anchor
    ttde_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .arr_valid (arr_valid),
        .arr_ready (arr_ready),
        .arr       (arr),
        .result    (result)
    );

endmodule

[hw/rtl/ttde_arrival.sv]
`include "truncated_time_of_day_expander_top_assert.svh"

module ttde_arrival (
    input  logic               clk,
    input  logic               rst_n,
    ttde_report_if.sink        report,
    output logic               arr_valid,
    input  logic               arr_ready,
    output ttde_pkg::ttde_arr_t arr
);
    import ttde_pkg::*;

    // Input register
    logic              s0_valid_reg;
    logic [SEC_W-1:0]  s0_sec_reg;
    logic [NSEC_W-1:0] s0_nsec_reg;
    logic              s0_present_reg;
    logic [LSP_W-1:0]  s0_lsp_reg;

    // Reciprocal product stage
    logic                s1_valid_reg;
    logic [SEC_HI_W-1:0] s1_sec_hi_reg;
    logic [FRAC_W-1:0]   s1_sec_lo_reg;
    logic [SEC_Q_W-1:0]  s1_sec_q_reg;
    logic [NSEC_W-1:0]   s1_nsec_reg;
    logic [FRAC_W-1:0]   s1_nsec_q_reg;
    logic                s1_present_reg;
    logic [LSP_W-1:0]    s1_lsp_reg;

    // Arrival ticks stage
    logic      s2_valid_reg;
    ttde_arr_t s2_arr_reg;
    ttde_arr_t s2_arr_next;

    logic s0_ready;
    logic s1_ready;
    logic s2_ready;

    logic [SEC_PROD_W-1:0]  sec_prod;
    logic [NSEC_PROD_W-1:0] nsec_prod;
    logic [NSEC_W-1:0]      nsec_clamp;
    logic [SEC_HI_W-1:0]    sec_sub;
    logic [SEC_REM_W:0]     sec_rem_raw;
    logic [SEC_REM_W-1:0]   sec_rem;
    logic [NSEC_W-1:0]      nsec_sub;
    logic [FRAC_W-1:0]      frac;

    // Elastic chain: a stage loads when empty or when its successor takes it
    assign s2_ready     = !s2_valid_reg || arr_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign s0_ready     = !s0_valid_reg || s1_ready;
    assign report.ready = s0_ready;

    // Clamp nanoseconds and form quotient estimates by reciprocal multiply
    always_comb
    begin
        nsec_clamp = (s0_nsec_reg > NSEC_MAX) ? NSEC_MAX : s0_nsec_reg;
        sec_prod   = SEC_PROD_W'(s0_sec_reg[SEC_W-1:FRAC_W]) * SEC_PROD_W'(SEC_RECIP);
        nsec_prod  = NSEC_PROD_W'(nsec_clamp) * NSEC_PROD_W'(NSEC_RECIP);
    end

    // Correct the estimates by one step and pack the day ticks
    always_comb
    begin
        sec_sub     = s1_sec_hi_reg
                      - SEC_HI_W'(SEC_HI_W'(s1_sec_q_reg) * SEC_HI_W'(SEC_GROUPS));
        sec_rem_raw = sec_sub[SEC_REM_W:0];
        if (sec_rem_raw >= (SEC_REM_W + 1)'(SEC_GROUPS))
        begin
            sec_rem_raw = sec_rem_raw - (SEC_REM_W + 1)'(SEC_GROUPS);
        end
        sec_rem = sec_rem_raw[SEC_REM_W-1:0];

        nsec_sub = s1_nsec_reg - NSEC_W'(NSEC_W'(s1_nsec_q_reg) * NSEC_PER_TICK);
        frac     = (nsec_sub >= NSEC_PER_TICK) ? s1_nsec_q_reg + 1'b1 : s1_nsec_q_reg;

        s2_arr_next.ticks       = {sec_rem, s1_sec_lo_reg, frac};
        s2_arr_next.lsp_present = s1_present_reg;
        s2_arr_next.tod_lsp     = s1_lsp_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= report.valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s0_ready && report.valid)
        begin
            s0_sec_reg     <= report.arrival_sec;
            s0_nsec_reg    <= report.arrival_nsec;
            s0_present_reg <= report.lsp_present;
            s0_lsp_reg     <= report.tod_lsp;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_sec_hi_reg  <= s0_sec_reg[SEC_W-1:FRAC_W];
            s1_sec_lo_reg  <= s0_sec_reg[FRAC_W-1:0];
            s1_sec_q_reg   <= sec_prod[SEC_PROD_W-1:SEC_RECIP_SHIFT];
            s1_nsec_reg    <= nsec_clamp;
            s1_nsec_q_reg  <= nsec_prod[NSEC_RECIP_SHIFT+FRAC_W-1:NSEC_RECIP_SHIFT];
            s1_present_reg <= s0_present_reg;
            s1_lsp_reg     <= s0_lsp_reg;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_arr_reg <= s2_arr_next;
        end
    end

    assign arr_valid = s2_valid_reg;
    assign arr       = s2_arr_reg;

    `TTDE_ASSERT_IMP(a_arr_in_day, arr_valid, arr.ticks < DAY_TICKS)
    `TTDE_ASSERT_NXT(a_arr_hold, arr_valid && !arr_ready,
                     arr_valid && $stable(arr.ticks))

endmodule

[hw/rtl/ttde_expand.sv]
`include "truncated_time_of_day_expander_top_assert.svh"

module ttde_expand (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                arr_valid,
    output logic                arr_ready,
    input  ttde_pkg::ttde_arr_t arr,
    ttde_result_if.source       result
);
    import ttde_pkg::*;

    logic             anchor_valid_reg;
    logic [TOD_W-1:0] anchor_tod_reg;
    logic             out_valid_reg;
    logic [TOD_W-1:0] tod_reg;
    logic             from_arrival_reg;

    logic              fire;
    logic [TOD_W-1:0]  ref_tod;
    logic [HIGH_W-1:0] high;
    logic [TOD_W-1:0]  cand_same;
    logic [TOD_W-1:0]  cand_prev;
    logic [TOD_W-1:0]  cand_next;
    logic [TOD_W-1:0]  dist_same;
    logic [TOD_W-1:0]  dist_prev;
    logic [TOD_W-1:0]  dist_next;
    logic [TOD_W-1:0]  best;
    logic [TOD_W-1:0]  best_dist;
    logic [TOD_W-1:0]  tod_next;

    // Distance under day wraparound; a candidate past the day never wins
    function automatic logic [TOD_W-1:0] wrap_dist(input logic [TOD_W-1:0] t,
                                                   input logic [TOD_W-1:0] r);
        logic [TOD_W-1:0] d;
        d = (t > r) ? (t - r) : (r - t);
        if (t >= DAY_TICKS)
        begin
            return DAY_TICKS;
        end
        return (d > HALF_TICKS) ? (DAY_TICKS - d) : d;
    endfunction

    assign arr_ready = !out_valid_reg || result.ready;
    assign fire      = arr_valid && arr_ready;

    // Pick the reference and expand the truncated field around it
    always_comb
    begin
        ref_tod   = anchor_valid_reg ? anchor_tod_reg : arr.ticks;
        high      = ref_tod[TOD_W-1:LSP_W];
        cand_same = {high, arr.tod_lsp};
        cand_prev = (high != '0) ? {high - 1'b1, arr.tod_lsp} : {TOP_HIGH, arr.tod_lsp};
        cand_next = (high < TOP_HIGH) ? {high + 1'b1, arr.tod_lsp}
                                      : {{HIGH_W{1'b0}}, arr.tod_lsp};
        dist_same = wrap_dist(cand_same, ref_tod);
        dist_prev = wrap_dist(cand_prev, ref_tod);
        dist_next = wrap_dist(cand_next, ref_tod);

        // Earlier candidate keeps ties
        best      = cand_same;
        best_dist = dist_same;
        if (dist_prev < best_dist)
        begin
            best      = cand_prev;
            best_dist = dist_prev;
        end
        if (dist_next < best_dist)
        begin
            best = cand_next;
        end

        tod_next = arr.lsp_present ? best : ref_tod;
    end

    // Control state: anchor valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_valid_reg <= 1'b0;
            anchor_tod_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (arr_ready)
            begin
                out_valid_reg <= arr_valid;
            end
            if (fire)
            begin
                anchor_valid_reg <= 1'b1;
                anchor_tod_reg   <= tod_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tod_reg          <= tod_next;
            from_arrival_reg <= !anchor_valid_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.time_of_day  = tod_reg;
    assign result.from_arrival = from_arrival_reg;

    `TTDE_ASSERT_IMP(a_tod_in_day, result.valid, result.time_of_day < DAY_TICKS)
    `TTDE_ASSERT_NXT(a_anchor_follows, fire,
                     result.valid && anchor_valid_reg && (anchor_tod_reg == result.time_of_day))

endmodule

[verif/time_of_day_checker.sv]
`timescale 1ns / 1ps

// Watch both channels, predict each time-of-day result and compare it with
// what the expander returns, in order.
module time_of_day_checker (
    input  logic   clk,
    input  logic   rst_n,
    ttde_report_if report,
    ttde_result_if result,
    output int     mismatches,
    output int     outstanding,
    output int     results_checked,
    output int     midnight_crossings
);
    import ttde_pkg::*;

    localparam logic [31:0] WINDOW_MASK = 32'hFFFF_0000;
    localparam logic [31:0] WINDOW_STEP = 32'h0001_0000;
    localparam logic [31:0] DAY         = 32'(DAY_TICKS);
    localparam logic [31:0] DAY_MIDPOINT = 32'(HALF_TICKS);
    localparam logic [31:0] LAST_WINDOW = (DAY - 32'd1) & WINDOW_MASK;
    localparam logic [63:0] NSEC_CAP    = 64'd999_999_999;
    localparam int          MAX_PRINTED = 40;

    typedef struct packed {
        logic [TOD_W-1:0] tod;
        logic             from_arrival;
    } tod_result_t;

    logic          anchor_set;
    logic [31:0]   anchor;
    tod_result_t   tod_expected_q[$];

    // Fold the arrival time into the day, in 1/128 s ticks
    function automatic logic [31:0] arrival_ticks_of(logic [SEC_W-1:0] sec,
                                                     logic [NSEC_W-1:0] nsec);
        logic [63:0] s;
        logic [63:0] ns;
        s  = 64'(sec) % 64'(DAY_SECONDS);
        ns = (64'(nsec) > NSEC_CAP) ? NSEC_CAP : 64'(nsec);
        return 32'(s * 64'(TICKS_PER_SEC) + (ns * 64'(TICKS_PER_SEC)) / 64'd1_000_000_000);
    endfunction

    // Distance around the day; a tick past the day never wins
    function automatic logic [31:0] day_distance(logic [31:0] t, logic [31:0] base);
        logic [31:0] d;
        if (t >= DAY)
            return DAY;
        d = (t > base) ? t - base : base - t;
        return (d > DAY_MIDPOINT) ? DAY - d : d;
    endfunction

    // Place the low bits in the window of base or either neighbor, nearest wins
    function automatic logic [31:0] nearest_in_day(logic [LSP_W-1:0] low, logic [31:0] base,
                                                   output logic crossed);
        logic [31:0] high;
        logic [31:0] cand_same;
        logic [31:0] cand_prev;
        logic [31:0] cand_next;
        logic [31:0] best;
        logic [31:0] best_d;
        logic [31:0] d;
        high      = base & WINDOW_MASK;
        cand_same = high | 32'(low);
        cand_prev = (high > 0) ? cand_same - WINDOW_STEP : (LAST_WINDOW | 32'(low));
        cand_next = (high < LAST_WINDOW) ? cand_same + WINDOW_STEP : 32'(low);
        best      = cand_same;
        best_d    = day_distance(cand_same, base);
        crossed   = 1'b0;
        d = day_distance(cand_prev, base);
        if (d < best_d)
        begin
            best    = cand_prev;
            best_d  = d;
            crossed = (high == 0);
        end
        d = day_distance(cand_next, base);
        if (d < best_d)
        begin
            best    = cand_next;
            crossed = (high == LAST_WINDOW);
        end
        return best;
    endfunction

    // Print one line per mismatch, keep the log short, count them all
    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] %s", $time, what);
        mismatches++;
    endtask

    // Compare the result transaction, then predict from the report transaction
    always @(posedge clk or negedge rst_n)
    begin
        tod_result_t got;
        tod_result_t want;
        logic [31:0] base;
        logic [31:0] tod;
        logic        crossed;
        if (!rst_n)
        begin
            anchor_set = 1'b0;
            anchor     = '0;
            tod_expected_q.delete();
            mismatches         = 0;
            outstanding        = 0;
            results_checked    = 0;
            midnight_crossings = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.tod          = result.time_of_day;
                got.from_arrival = result.from_arrival;
                if (tod_expected_q.size() == 0)
                    flag_mismatch($sformatf("result tod=%0d with nothing expected", got.tod));
                else
                begin
                    want = tod_expected_q.pop_front();
                    results_checked++;
                    if (got.tod !== want.tod)
                        flag_mismatch($sformatf("time_of_day %0d, expected %0d",
                                                got.tod, want.tod));
                    if (got.from_arrival !== want.from_arrival)
                        flag_mismatch($sformatf("from_arrival %0b, expected %0b",
                                                got.from_arrival, want.from_arrival));
                end
            end
            if (report.valid && report.ready)
            begin
                base = anchor_set ? anchor
                                  : arrival_ticks_of(report.arrival_sec, report.arrival_nsec);
                if (report.lsp_present)
                    tod = nearest_in_day(report.tod_lsp, base, crossed);
                else
                begin
                    tod     = base;
                    crossed = 1'b0;
                end
                want.tod          = tod[TOD_W-1:0];
                want.from_arrival = !anchor_set;
                if (crossed)
                    midnight_crossings++;
                anchor     = 32'(want.tod);
                anchor_set = 1'b1;
                tod_expected_q.push_back(want);
            end
            outstanding = tod_expected_q.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ttde_pkg::*;

    localparam int RANDOM_REPORTS = 1400;
    localparam int CALM_TAIL      = 200;

    typedef enum logic [1:0] {SEG_WALK, SEG_NOISE, SEG_HOLD} segment_t;

    localparam logic [LSP_W-1:0] DIRECTED_LSP [17] = '{
        16'h4000, 16'hC000, 16'h3000, 16'hB000, 16'h0000, 16'hFFFF, 16'h0000,
        16'h0000, 16'h9000, 16'h2000, 16'hB000, 16'h4000, 16'h1000, 16'hA000,
        16'hBFFF, 16'h0000, 16'h5555
    };

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             calm  = 1'b0;
    logic [LSP_W-1:0] last_lsp = '0;
    int               sent = 0;
    int               absent_sent = 0;
    int               mismatches;
    int               outstanding;
    int               results_checked;
    int               midnight_crossings;

    ttde_report_if report_ch();
    ttde_result_if result_ch();

    truncated_time_of_day_expander_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report_ch),
        .result (result_ch)
    );

    time_of_day_checker tod_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .report             (report_ch),
        .result             (result_ch),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .results_checked    (results_checked),
        .midnight_crossings (midnight_crossings)
    );

    always #5 clk = ~clk;

    // Hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stall the result side in bursts, none in the tail of the run
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    // Drive one report transaction, with an optional idle burst ahead of it
    task automatic send_report(logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] nsec,
                               logic present, logic [LSP_W-1:0] lsp);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            report_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        report_ch.valid        = 1'b1;
        report_ch.arrival_sec  = sec;
        report_ch.arrival_nsec = nsec;
        report_ch.lsp_present  = present;
        report_ch.tod_lsp      = lsp;
        @(posedge clk);
        while (!report_ch.ready)
            @(posedge clk);
        sent++;
        if (present)
            last_lsp = lsp;
        else
            absent_sent++;
    endtask

    // Arrival time only matters for the first report, so keep it random
    task automatic send_lsp(logic present, logic [LSP_W-1:0] lsp);
        send_report(SEC_W'({$urandom_range(0, 3), $urandom}), NSEC_W'($urandom), present, lsp);
    endtask

    initial
    begin
        segment_t         seg;
        int               left;
        int               len;
        logic             forward;
        logic [LSP_W-1:0] stride;

        report_ch.valid        = 1'b0;
        report_ch.arrival_sec  = '0;
        report_ch.arrival_nsec = '0;
        report_ch.lsp_present  = 1'b0;
        report_ch.tod_lsp      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Start on the last second of a day with nanoseconds past range, so the
        // same window lands beyond the day and the next one wraps to midnight
        send_report(34'd17179862399, 30'h3FFF_FFFF, 1'b1, 16'hC000);
        send_report('0, '0, 1'b0, 16'hFFFF);
        // Hand-placed steps: ties, window changes both ways, both day ends
        foreach (DIRECTED_LSP[i])
            send_lsp(DIRECTED_LSP[i] != 16'h5555, DIRECTED_LSP[i]);
        send_lsp(1'b1, 16'hFFFF);

        // Mostly walk the anchor around the day, with noise and holds between
        left = RANDOM_REPORTS;
        while (left > 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: seg = SEG_WALK;
                7, 8:                seg = SEG_NOISE;
                default:             seg = SEG_HOLD;
            endcase
            forward = ($urandom_range(0, 4) != 0);
            stride  = ($urandom_range(0, 5) == 0) ? 16'h8000
                                                  : LSP_W'($urandom_range(16'h4000, 16'h7FFF));
            len     = (seg == SEG_WALK) ? $urandom_range(20, 80) : $urandom_range(3, 20);
            for (int i = 0; i < len && left > 0; i++)
            begin
                calm = (left <= CALM_TAIL);
                case (seg)
                    SEG_WALK:
                        if ($urandom_range(0, 7) == 0)
                            send_lsp(1'b0, LSP_W'($urandom));
                        else
                            send_lsp(1'b1, forward ? last_lsp + stride : last_lsp - stride);
                    SEG_NOISE:
                        send_lsp(1'($urandom_range(0, 1)), LSP_W'($urandom));
                    default:
                        send_lsp(1'b1, last_lsp + LSP_W'($urandom_range(0, 2)) - 16'd1);
                endcase
                left--;
            end
        end

        // Drain, then give a late extra result time to show up
        @(negedge clk);
        report_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);

        $display("Drove %0d reports, %0d without the truncated field, under random gaps and stalls",
                 sent, absent_sent);
        $display("Checked %0d results, %0d of them expanded across midnight",
                 results_checked, midnight_crossings);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
